FILE: src/msb_pkg.sv
// ============================================================================
// msb_pkg
// Shared types and constants for the multi-stack shared buffer core.
// ============================================================================
`default_nettype none

package msb_pkg;

   localparam int ACTION_WIDTH   = 2;
   localparam int STACK_ID_WIDTH = 2;
   localparam int VALUE_WIDTH    = 32;
   localparam int STATUS_WIDTH   = 2;
   localparam int STACK_SLOTS    = 2 ** STACK_ID_WIDTH;

   localparam int NUM_STACKS_DEFAULT = 4;
   localparam int CAPACITY_DEFAULT   = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_PUSH = 2'd0,
      ACT_POP  = 2'd1,
      ACT_PEEK = 2'd2,
      ACT_NOP  = 2'd3
   } action_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      PH_IDLE = 1'b0,
      PH_EXEC = 1'b1
   } phase_type;

   typedef struct packed {
      action_type                       action;
      logic [STACK_ID_WIDTH-1:0]        stack_id;
      logic signed [VALUE_WIDTH-1:0]    value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0]    data;
      status_type                       status;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic out_free;
   } eng_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } eng_stat_type;

endpackage

`default_nettype wire

FILE: src/msb_ram.sv
// ============================================================================
// msb_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module msb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output      logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: src/msb_engine.sv
// ============================================================================
// msb_engine
// Stack heads, free list head and fill count, with the link and data RAMs.
// Reads on acceptance, then modifies and writes back in the execute phase.
// ============================================================================
`default_nettype none

module msb_engine #(
   parameter int NUM_STACKS = msb_pkg::NUM_STACKS_DEFAULT,
   parameter int CAPACITY   = msb_pkg::CAPACITY_DEFAULT,
   parameter int DATA_WIDTH = msb_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire msb_pkg::eng_ctrl_type ctrl,
   input  wire msb_pkg::req_type      req,
   output      msb_pkg::eng_stat_type stat,
   output      msb_pkg::rsp_type      rsp
);

   import msb_pkg::*;

   localparam int LW         = $clog2(CAPACITY + 1);
   localparam int AW         = $clog2(CAPACITY);
   localparam int HEAD_DEPTH = (NUM_STACKS < STACK_SLOTS) ? NUM_STACKS : STACK_SLOTS;
   localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);

   phase_type                 phase_ff, phase_in;
   req_type                   op_ff;
   logic [LW-1:0]             e_ff;
   logic                      hit_ff;
   logic [LW-1:0]             head_ff [HEAD_DEPTH];
   logic [LW-1:0]             free_head_ff, free_head_in;
   logic [LW-1:0]             fill_ff, fill_in;

   logic [LW-1:0]             head_req;
   logic                      sid_ok_req;
   logic [LW-1:0]             e_req;
   logic                      hit_req;
   logic                      rd_en;

   logic [LW-1:0]             head_op;
   logic [LW-1:0]             link_rd;
   logic [LW-1:0]             link_next;
   logic [DATA_WIDTH-1:0]     data_rd;
   logic [DATA_WIDTH-1:0]     data_wr;
   logic [VALUE_WIDTH-1:0]    data_out;

   logic                      commit;
   logic                      link_we;
   logic [LW-1:0]             link_wd;
   logic                      data_we;
   logic                      head_we;
   logic [LW-1:0]             head_wd;

   // ---- acceptance: select the entry to read
   always_comb begin
      head_req = NULL_LINK;
      for (int i = 0; i < HEAD_DEPTH; i++) begin
         if (req.stack_id == STACK_ID_WIDTH'(i)) begin
            head_req = head_ff[i];
         end
      end
      sid_ok_req = (HEAD_DEPTH == STACK_SLOTS) ||
                   (req.stack_id < STACK_ID_WIDTH'(HEAD_DEPTH));
      e_req = (req.action == ACT_PUSH) ? free_head_ff : head_req;
      hit_req = sid_ok_req && (e_req < NULL_LINK) && (req.action != ACT_NOP);
      rd_en = ctrl.start && hit_req;
   end

   // ---- execute: head of the addressed stack
   always_comb begin
      head_op = NULL_LINK;
      for (int i = 0; i < HEAD_DEPTH; i++) begin
         if (op_ff.stack_id == STACK_ID_WIDTH'(i)) begin
            head_op = head_ff[i];
         end
      end
   end

   // Untouched entries chain to the next one; the last one chains to null.
   assign link_next = (e_ff < fill_ff) ? link_rd : e_ff + LW'(1);

   generate
      if (DATA_WIDTH > VALUE_WIDTH) begin : g_wide
         assign data_wr  = {{(DATA_WIDTH - VALUE_WIDTH){1'b0}}, op_ff.value};
         assign data_out = data_rd[VALUE_WIDTH-1:0];
      end else if (DATA_WIDTH == VALUE_WIDTH) begin : g_equal
         assign data_wr  = op_ff.value;
         assign data_out = data_rd;
      end else begin : g_narrow
         assign data_wr  = op_ff.value[DATA_WIDTH-1:0];
         assign data_out = {{(VALUE_WIDTH - DATA_WIDTH){1'b0}}, data_rd};
      end
   endgenerate

   always_comb begin
      phase_in     = phase_ff;
      commit       = 1'b0;
      link_we      = 1'b0;
      link_wd      = head_op;
      data_we      = 1'b0;
      head_we      = 1'b0;
      head_wd      = e_ff;
      free_head_in = free_head_ff;
      fill_in      = fill_ff;
      rsp.data     = '0;
      rsp.status   = ST_OK;
      unique case (phase_ff)
         PH_IDLE: begin
            if (ctrl.start) begin
               phase_in = PH_EXEC;
            end
         end
         PH_EXEC: begin
            commit = ctrl.out_free;
            if (ctrl.out_free) begin
               phase_in = PH_IDLE;
            end
            case (op_ff.action)
               ACT_PUSH: begin
                  if (hit_ff) begin
                     link_we      = commit;
                     link_wd      = head_op;
                     data_we      = commit;
                     head_we      = commit;
                     head_wd      = e_ff;
                     free_head_in = link_next;
                     fill_in      = (e_ff < fill_ff) ? fill_ff : e_ff + LW'(1);
                  end else begin
                     rsp.status = ST_FULL;
                  end
               end
               ACT_POP: begin
                  if (hit_ff) begin
                     rsp.data     = data_out;
                     link_we      = commit;
                     link_wd      = free_head_ff;
                     head_we      = commit;
                     head_wd      = link_rd;
                     free_head_in = e_ff;
                  end else begin
                     rsp.status = ST_EMPTY;
                  end
               end
               ACT_PEEK: begin
                  if (hit_ff) begin
                     rsp.data = data_out;
                  end else begin
                     rsp.status = ST_EMPTY;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      stat.busy = (phase_ff == PH_EXEC);
      stat.done = commit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         free_head_ff <= '0;
         fill_ff      <= '0;
         for (int i = 0; i < HEAD_DEPTH; i++) begin
            head_ff[i] <= NULL_LINK;
         end
      end else begin
         phase_ff <= phase_in;
         if (commit) begin
            free_head_ff <= free_head_in;
            fill_ff      <= fill_in;
         end
         for (int i = 0; i < HEAD_DEPTH; i++) begin
            if (head_we && op_ff.stack_id == STACK_ID_WIDTH'(i)) begin
               head_ff[i] <= head_wd;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         op_ff  <= req;
         e_ff   <= e_req;
         hit_ff <= hit_req;
      end
   end

   msb_ram #(
      .WIDTH (LW),
      .DEPTH (CAPACITY)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (e_ff[AW-1:0]),
      .wr_data (link_wd),
      .rd_en   (rd_en),
      .rd_addr (e_req[AW-1:0]),
      .rd_data (link_rd)
   );

   msb_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (e_ff[AW-1:0]),
      .wr_data (data_wr),
      .rd_en   (rd_en),
      .rd_addr (e_req[AW-1:0]),
      .rd_data (data_rd)
   );

endmodule

`default_nettype wire

FILE: src/multi_stack_shared_buffer_core.sv
// ============================================================================
// multi_stack_shared_buffer_core
// Several stacks sharing one entry buffer through a linked free list.
//
//   channel  dir  tdata                  tuser
//   req      in   value[31:0]            action[1:0], stack_id[3:2]
//   rsp      out  data[31:0]             status[1:0]
//
// In each transaction the link and data RAMs are read on acceptance, and the
// execute phase writes back and loads the result register.
// req_tready is low only in the execute phase, which a stalled result extends.
// Reset is synchronous; it empties every stack and takes effect at once,
// with no clearing pass (a fill count stands in for the initial free chain).
// A stalled result holds execute; the result register frees the input side.
// ============================================================================
`default_nettype none

module multi_stack_shared_buffer_core #(
   parameter int NUM_STACKS = msb_pkg::NUM_STACKS_DEFAULT,
   parameter int CAPACITY   = msb_pkg::CAPACITY_DEFAULT,
   parameter int DATA_WIDTH = msb_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,   // value[31:0]
   input  wire logic [3:0]  req_tuser,   // action[1:0], stack_id[3:2]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // data[31:0]
   output      logic [1:0]  rsp_tuser    // status[1:0]
);

   import msb_pkg::*;

   eng_ctrl_type ctrl;
   eng_stat_type stat;
   req_type      req;
   rsp_type      eng_rsp;
   rsp_type      rsp_ff;
   logic         rsp_valid_ff, rsp_valid_in;

   assign req.action   = action_type'(req_tuser[1:0]);
   assign req.stack_id = req_tuser[3:2];
   assign req.value    = req_tdata;

   assign req_tready    = !stat.busy;
   assign ctrl.start    = req_tvalid && !stat.busy;
   assign ctrl.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (stat.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.done) begin
         rsp_ff <= eng_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.data;
   assign rsp_tuser  = rsp_ff.status;

   msb_engine #(
      .NUM_STACKS (NUM_STACKS),
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .req   (req),
      .stat  (stat),
      .rsp   (eng_rsp)
   );

endmodule

`default_nettype wire

FILE: src/msb_checker.sv
// ============================================================================
// msb_checker
// Port-level checks on the multi-stack shared buffer core.
// ============================================================================
`default_nettype none

module msb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   import msb_pkg::*;

   logic       req_acc;
   logic       rsp_acc;
   logic [1:0] pending_ff, pending_in;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   always_comb begin
      pending_in = pending_ff;
      if (req_acc && !rsp_acc) begin
         pending_in = pending_ff + 2'd1;
      end else if (rsp_acc && !req_acc) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> pending_ff != 2'd0)
      else $error("result without a pending transaction");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 2'd2 |-> !req_tready)
      else $error("more than two transactions in flight");

   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata == 32'd0)
      else $error("data on a failed transaction");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind multi_stack_shared_buffer_core msb_checker u_msb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

FILE: test/tb_multi_stack_shared_buffer_core.sv
// ============================================================================
// tb_multi_stack_shared_buffer_core
// Self-checking bench for the shared-buffer stack core. A queue of push, pop,
// peek and no-op transactions feeds a stream driver. An in-bench model of the
// stacks and free chain predicts each response at request acceptance. A
// monitor compares every response with the oldest prediction. Both sides
// idle at random, apart from one long burst with no idling.
// ============================================================================

module tb_multi_stack_shared_buffer_core;
   timeunit 1ns;
   timeprecision 1ps;

   import msb_pkg::*;

   localparam int STACKS      = 4;
   localparam int BUF_ENTRIES = 16;
   localparam int RANDOM_OPS  = 750;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_WAIT  = 8;
   localparam logic [4:0] NULL_LINK = 5'(BUF_ENTRIES);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // value[31:0]
   logic [3:0]  req_tuser = '0;    // action[1:0], stack_id[3:2]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // data[31:0]
   logic [1:0]  rsp_tuser;         // status[1:0]

   req_type pending_ops[$];
   rsp_type expected_rsp[$];
   req_type cur_req;
   int      ops_sent = 0;
   int      errors = 0;
   int      stall_cycles = 0;
   logic    quiet;

   logic [31:0] word_mem[BUF_ENTRIES];
   logic [4:0]  link_mem[BUF_ENTRIES];
   logic [4:0]  stack_top[STACKS];
   logic [4:0]  free_top;

   multi_stack_shared_buffer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   assign quiet = (ops_sent >= 300) && (ops_sent < 430);

   function automatic void clear_stacks();
      for (int i = 0; i < BUF_ENTRIES; i++) begin
         word_mem[i] = '0;
         link_mem[i] = 5'(i + 1);
      end
      for (int i = 0; i < STACKS; i++) begin
         stack_top[i] = NULL_LINK;
      end
      free_top = '0;
   endfunction

   function automatic rsp_type apply_stack_op(req_type op);
      rsp_type    r;
      logic [4:0] e;
      logic       sid_ok;
      r.data   = '0;
      r.status = ST_OK;
      sid_ok   = int'(op.stack_id) < STACKS;
      case (op.action)
         ACT_PUSH: begin
            e = free_top;
            if (!sid_ok || e >= NULL_LINK) begin
               r.status = ST_FULL;
            end else begin
               free_top = link_mem[e];
               link_mem[e] = stack_top[op.stack_id];
               stack_top[op.stack_id] = e;
               word_mem[e] = op.value;
            end
         end
         ACT_POP, ACT_PEEK: begin
            e = sid_ok ? stack_top[op.stack_id] : NULL_LINK;
            if (e >= NULL_LINK) begin
               r.status = ST_EMPTY;
            end else begin
               r.data = word_mem[e];
               if (op.action == ACT_POP) begin
                  stack_top[op.stack_id] = link_mem[e];
                  link_mem[e] = free_top;
                  free_top = e;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic add_op(action_type act, logic [1:0] sid, logic [31:0] val);
      req_type op;
      op.action   = act;
      op.stack_id = sid;
      op.value    = val;
      pending_ops.insert(pending_ops.size(), op);
   endtask

   // driver: predict on acceptance, then present the next transaction
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rsp.insert(expected_rsp.size(), apply_stack_op(cur_req));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_ops.size() > 0 && (quiet || $urandom_range(99) >= 24)) begin
               cur_req = pending_ops.pop_front();
               ops_sent++;
               req_tvalid <= 1'b1;
               req_tdata  <= cur_req.value;
               req_tuser  <= {cur_req.stack_id, cur_req.action};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= 24);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected response data=%h status=%0d",
                        $time, rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               rsp_type exp_rsp;
               exp_rsp = expected_rsp.pop_front();
               if (rsp_tdata !== exp_rsp.data) begin
                  $display("%0t: data mismatch expected %h actual %h",
                           $time, exp_rsp.data, rsp_tdata);
                  errors++;
               end
               if (rsp_tuser !== exp_rsp.status) begin
                  $display("%0t: status mismatch expected %0d actual %0d",
                           $time, exp_rsp.status, rsp_tuser);
                  errors++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      int          kind, len, fav, roll, push_pct, pop_pct, counted;
      action_type  act;
      logic [1:0]  sid;
      logic [31:0] val;

      clear_stacks();

      add_op(ACT_PEEK, 2'd0, 32'h0000_0000);
      add_op(ACT_POP,  2'd3, 32'h1234_5678);
      add_op(ACT_NOP,  2'd2, 32'hFFFF_FFFF);
      add_op(ACT_PUSH, 2'd0, 32'h8000_0000);
      add_op(ACT_PUSH, 2'd1, 32'h7FFF_FFFF);
      add_op(ACT_PEEK, 2'd0, 32'hFFFF_FFFF);
      add_op(ACT_PEEK, 2'd1, 32'h0000_0000);
      for (int i = 0; i < BUF_ENTRIES - 2; i++) begin
         case (i % 4)
            0: val = 32'h0000_0000;
            1: val = 32'hFFFF_FFFF;
            2: val = 32'h5555_5555;
            default: val = 32'hAAAA_AAAA;
         endcase
         add_op(ACT_PUSH, 2'(i + 2), val);
      end
      add_op(ACT_PUSH, 2'd3, 32'hDEAD_BEEF);
      add_op(ACT_POP,  2'd1, 32'h0000_0000);
      add_op(ACT_POP,  2'd0, 32'h0000_0000);

      counted = pending_ops.size();
      while (counted < RANDOM_OPS) begin
         kind = $urandom_range(2);
         len  = $urandom_range(40, 10);
         fav  = $urandom_range(STACKS - 1);
         case (kind)
            0: begin push_pct = 70; pop_pct = 12; end
            1: begin push_pct = 15; pop_pct = 65; end
            default: begin push_pct = 40; pop_pct = 35; end
         endcase
         for (int n = 0; n < len; n++) begin
            roll = $urandom_range(99);
            if (roll < 4) act = ACT_NOP;
            else if (roll < 4 + push_pct) act = ACT_PUSH;
            else if (roll < 4 + push_pct + pop_pct) act = ACT_POP;
            else act = ACT_PEEK;
            sid = ($urandom_range(99) < 60) ? 2'(fav) : 2'($urandom_range(STACKS - 1));
            case ($urandom_range(7))
               0: val = 32'h8000_0000;
               1: val = 32'h7FFF_FFFF;
               2: val = 32'h0000_0000;
               3: val = 32'hFFFF_FFFF;
               default: val = $urandom();
            endcase
            add_op(act, sid, val);
            counted++;
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || req_tvalid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (expected_rsp.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, expected_rsp.size());
         errors++;
      end
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
